### hdl/cabb_pkg.sv
// shared types, register indexes and arithmetic helpers for the clipped alpha blit
package cabb_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int DIM_W   = 13;  // dimension registers
  localparam int CTR_W   = 14;  // signed centre coordinates
  localparam int POS_W   = 12;  // sprite coordinates
  localparam int CRD_W   = 16;  // signed destination coordinates
  localparam int IDX_W   = 24;  // destination pixel index
  localparam int PROD_W  = 2 * DIM_W;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 14;

  localparam logic [CFG_IW-1:0] CFG_PAINT_MODE = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SRC_WIDTH  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SRC_HEIGHT = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_DST_WIDTH  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DST_HEIGHT = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_CENTER_X   = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_CENTER_Y   = 3'd6;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic                    paint_mode;
    logic [DIM_W-1:0]        src_width;
    logic [DIM_W-1:0]        src_height;
    logic [DIM_W-1:0]        dst_width;
    logic [DIM_W-1:0]        dst_height;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
  } cfg_t;

  // floor(p / 255) for p up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

### hdl/cabb_cfg_regs.sv
// configuration register file with dimension saturation
module cabb_cfg_regs #(
  parameter int MAX_DIM = cabb_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [cabb_pkg::CFG_IW-1:0]   wr_index,
  input  logic [cabb_pkg::CFG_DW-1:0]   wr_data,
  output cabb_pkg::cfg_t                cfg
);

  function automatic logic [cabb_pkg::DIM_W-1:0] clamp_dim(
    input logic [cabb_pkg::DIM_W-1:0] v
  );
    logic [cabb_pkg::DIM_W-1:0] d;
    d = v;
    if (32'(v) > MAX_DIM) begin
      d = cabb_pkg::DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  cabb_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        cabb_pkg::CFG_PAINT_MODE: cfg_nxt.paint_mode = wr_data[0];
        cabb_pkg::CFG_SRC_WIDTH:  cfg_nxt.src_width  = clamp_dim(wr_data[cabb_pkg::DIM_W-1:0]);
        cabb_pkg::CFG_SRC_HEIGHT: cfg_nxt.src_height = clamp_dim(wr_data[cabb_pkg::DIM_W-1:0]);
        cabb_pkg::CFG_DST_WIDTH:  cfg_nxt.dst_width  = clamp_dim(wr_data[cabb_pkg::DIM_W-1:0]);
        cabb_pkg::CFG_DST_HEIGHT: cfg_nxt.dst_height = clamp_dim(wr_data[cabb_pkg::DIM_W-1:0]);
        cabb_pkg::CFG_CENTER_X:   cfg_nxt.center_x   = $signed(wr_data);
        cabb_pkg::CFG_CENTER_Y:   cfg_nxt.center_y   = $signed(wr_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paint_mode <= 1'b0;
      cfg_r.src_width  <= cabb_pkg::DIM_W'(1);
      cfg_r.src_height <= cabb_pkg::DIM_W'(1);
      cfg_r.dst_width  <= clamp_dim(cabb_pkg::DIM_W'(4096));
      cfg_r.dst_height <= clamp_dim(cabb_pkg::DIM_W'(4096));
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/clipped_alpha_blit_blend.sv
// top level: three-stage clipped premultiplied alpha blit pipeline
// a transfer accepted at a clock edge is registered in stage one, stage two and the output stage, in that order
// throughput: one pixel per cycle, busy is never raised; the receiver cannot stall
// reset: synchronous active-low rst_n clears stage valid bits and loads register defaults
// config writes are never stalled (cfg_ready always high)
module clipped_alpha_blit_blend #(
  parameter int MAX_DIM = cabb_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [cabb_pkg::POS_W-1:0]    in_pos_x,
  input  logic [cabb_pkg::POS_W-1:0]    in_pos_y,
  input  logic [7:0]                    in_src_a,
  input  logic [7:0]                    in_src_r,
  input  logic [7:0]                    in_src_g,
  input  logic [7:0]                    in_src_b,
  input  logic [7:0]                    in_under_a,
  input  logic [7:0]                    in_under_r,
  input  logic [7:0]                    in_under_g,
  input  logic [7:0]                    in_under_b,
  // result channel
  output logic                          out_valid,
  output logic                          out_write_enable,
  output logic [cabb_pkg::IDX_W-1:0]    out_dest_index,
  output logic [7:0]                    out_a,
  output logic [7:0]                    out_r,
  output logic [7:0]                    out_g,
  output logic [7:0]                    out_b,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cabb_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [cabb_pkg::CFG_DW-1:0]   cfg_data
);

  cabb_pkg::cfg_t cfg;

  cabb_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  logic in_xfer;
  assign in_xfer = start & ~busy;

  // ---------------------------------------------------------------------
  // stage 1: destination coordinates, sprite clip, blend mode decision
  // ---------------------------------------------------------------------
  logic signed [cabb_pkg::CRD_W-1:0] x_s0, y_s0;
  logic                              in_sprite_s0;

  always_comb begin
    x_s0 = cabb_pkg::CRD_W'(cfg.center_x)
         - $signed({4'b0, cfg.src_width[cabb_pkg::DIM_W-1:1]})
         + $signed({4'b0, in_pos_x});
    y_s0 = cabb_pkg::CRD_W'(cfg.center_y)
         - $signed({4'b0, cfg.src_height[cabb_pkg::DIM_W-1:1]})
         + $signed({4'b0, in_pos_y});
    in_sprite_s0 = ({1'b0, in_pos_x} < cfg.src_width) &&
                   ({1'b0, in_pos_y} < cfg.src_height);
  end

  logic                              v1_r;
  logic signed [cabb_pkg::CRD_W-1:0] x1_r, y1_r;
  logic                              in_sprite1_r, opaque1_r, transp1_r;
  logic [7:0]                        inv1_r;
  logic [7:0]                        sa1_r, sr1_r, sg1_r, sb1_r;
  logic [7:0]                        ua1_r, ur1_r, ug1_r, ub1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    x1_r         <= x_s0;
    y1_r         <= y_s0;
    in_sprite1_r <= in_sprite_s0;
    // opaque copy when mode is copy or source fully covers
    opaque1_r    <= ~cfg.paint_mode | (in_src_a == cabb_pkg::ALPHA_OPAQUE);
    // fully transparent source in blend mode writes nothing
    transp1_r    <= cfg.paint_mode & (in_src_a == 8'd0);
    inv1_r       <= cabb_pkg::ALPHA_OPAQUE - in_src_a;
    sa1_r <= in_src_a;   sr1_r <= in_src_r;   sg1_r <= in_src_g;   sb1_r <= in_src_b;
    ua1_r <= in_under_a; ur1_r <= in_under_r; ug1_r <= in_under_g; ub1_r <= in_under_b;
  end

  // ---------------------------------------------------------------------
  // stage 2: destination clip, row offset multiply, channel products
  // ---------------------------------------------------------------------
  logic inside_s1;
  always_comb begin
    inside_s1 = in_sprite1_r && !x1_r[cabb_pkg::CRD_W-1] && !y1_r[cabb_pkg::CRD_W-1] &&
                (x1_r[cabb_pkg::CRD_W-2:0] < {2'b0, cfg.dst_width}) &&
                (y1_r[cabb_pkg::CRD_W-2:0] < {2'b0, cfg.dst_height});
  end

  logic                              v2_r, we2_r, opaque2_r;
  logic [cabb_pkg::DIM_W-1:0]        x2_r;
  logic [cabb_pkg::PROD_W-1:0]       row2_r;
  logic [15:0]                       pa2_r, pr2_r, pg2_r, pb2_r;
  logic [7:0]                        sa2_r, sr2_r, sg2_r, sb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    we2_r     <= inside_s1 & ~transp1_r;
    opaque2_r <= opaque1_r;
    // inside the destination both coordinates fit the dimension width
    x2_r      <= x1_r[cabb_pkg::DIM_W-1:0];
    row2_r    <= cfg.dst_width * y1_r[cabb_pkg::DIM_W-1:0];
    pa2_r     <= inv1_r * ua1_r;
    pr2_r     <= inv1_r * ur1_r;
    pg2_r     <= inv1_r * ug1_r;
    pb2_r     <= inv1_r * ub1_r;
    sa2_r <= sa1_r; sr2_r <= sr1_r; sg2_r <= sg1_r; sb2_r <= sb1_r;
  end

  // ---------------------------------------------------------------------
  // stage 3: index add, divide by 255, channel sums, zero on no write
  // ---------------------------------------------------------------------
  logic [cabb_pkg::PROD_W-1:0] idx_sum;
  logic [7:0]                  a_s2, r_s2, g_s2, b_s2;

  always_comb begin
    idx_sum = row2_r + {{(cabb_pkg::PROD_W-cabb_pkg::DIM_W){1'b0}}, x2_r};
    if (opaque2_r) begin
      a_s2 = sa2_r; r_s2 = sr2_r; g_s2 = sg2_r; b_s2 = sb2_r;
    end else begin
      a_s2 = sa2_r + cabb_pkg::div255(pa2_r);
      r_s2 = sr2_r + cabb_pkg::div255(pr2_r);
      g_s2 = sg2_r + cabb_pkg::div255(pg2_r);
      b_s2 = sb2_r + cabb_pkg::div255(pb2_r);
    end
  end

  logic                        out_valid_r, out_we_r;
  logic [cabb_pkg::IDX_W-1:0]  out_idx_r;
  logic [7:0]                  out_a_r, out_r_r, out_g_r, out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_we_r    <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
      out_we_r    <= v2_r & we2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we2_r) begin
      out_idx_r <= idx_sum[cabb_pkg::IDX_W-1:0];
      out_a_r   <= a_s2;
      out_r_r   <= r_s2;
      out_g_r   <= g_s2;
      out_b_r   <= b_s2;
    end else begin
      out_idx_r <= '0;
      out_a_r   <= '0;
      out_r_r   <= '0;
      out_g_r   <= '0;
      out_b_r   <= '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_dest_index   = out_idx_r;
  assign out_a            = out_a_r;
  assign out_r            = out_r_r;
  assign out_g            = out_g_r;
  assign out_b            = out_b_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // every accepted pixel gives exactly one result once it has passed through the pipeline
  a_one_result: assert property (@(posedge clk)
    rst_n && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
    |-> (out_valid == $past(start && !busy, 3)))
    else $error("result strobe does not match accepted pixels");

  // a write is only flagged on a result cycle
  a_we_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_write_enable |-> out_valid)
    else $error("write enable without result strobe");

  // a result without a write carries all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable)
    |-> (out_dest_index == '0 && out_a == '0 && out_r == '0 &&
         out_g == '0 && out_b == '0))
    else $error("no-write result carries nonzero fields");

  // stage valid bits advance one stage per cycle
  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> v2_r)
    else $error("pixel lost between stage one and stage two");

endmodule

### tb/cabb_checker.sv
// blit checker: tracks register writes, predicts each pixel write and compares results
module cabb_checker #(
  parameter int MAX_DIM = cabb_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [cabb_pkg::POS_W-1:0]    in_pos_x,
  input  logic [cabb_pkg::POS_W-1:0]    in_pos_y,
  input  logic [7:0]                    in_src_a,
  input  logic [7:0]                    in_src_r,
  input  logic [7:0]                    in_src_g,
  input  logic [7:0]                    in_src_b,
  input  logic [7:0]                    in_under_a,
  input  logic [7:0]                    in_under_r,
  input  logic [7:0]                    in_under_g,
  input  logic [7:0]                    in_under_b,
  input  logic                          out_valid,
  input  logic                          out_write_enable,
  input  logic [cabb_pkg::IDX_W-1:0]    out_dest_index,
  input  logic [7:0]                    out_a,
  input  logic [7:0]                    out_r,
  input  logic [7:0]                    out_g,
  input  logic [7:0]                    out_b,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cabb_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [cabb_pkg::CFG_DW-1:0]   cfg_data,
  output int                            mismatches,
  output int                            in_flight
);
  import cabb_pkg::*;

  localparam int BYTE_MAX  = 255;
  localparam int DST_RESET = 4096;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [7:0]       a;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
  } pixel_write_t;

  cfg_t         blit_cfg;
  pixel_write_t pending_writes[$];
  int           accepted;
  int           retired;

  // low 13 bits, saturated at the largest dimension
  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DW-1:0] d);
    logic [DIM_W-1:0] v;
    v = d[DIM_W-1:0];
    if (int'(v) > MAX_DIM) v = DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [7:0] blend_byte(input logic [7:0] s, d, alpha);
    int t;
    t = int'(s) + ((BYTE_MAX - int'(alpha)) * int'(d)) / BYTE_MAX;
    return t[7:0];
  endfunction

  function automatic pixel_write_t predict_write(input cfg_t c,
      input logic [POS_W-1:0] px, py,
      input logic [7:0] sa, sr, sg, sb, ua, ur, ug, ub);
    pixel_write_t w;
    int x;
    int y;
    logic on_target;
    w = '0;
    x = int'(c.center_x) - int'(c.src_width >> 1) + int'(px);
    y = int'(c.center_y) - int'(c.src_height >> 1) + int'(py);
    on_target = int'(px) < int'(c.src_width) && int'(py) < int'(c.src_height) &&
                x >= 0 && y >= 0 && x < int'(c.dst_width) && y < int'(c.dst_height);
    if (!on_target) return w;
    if (!c.paint_mode || sa == ALPHA_OPAQUE) begin
      w.a = sa;
      w.r = sr;
      w.g = sg;
      w.b = sb;
    end else if (sa == 8'd0) begin
      return w;
    end else begin
      w.a = blend_byte(sa, ua, sa);
      w.r = blend_byte(sr, ur, sa);
      w.g = blend_byte(sg, ug, sa);
      w.b = blend_byte(sb, ub, sa);
    end
    w.we  = 1'b1;
    w.idx = IDX_W'(x + int'(c.dst_width) * y);
    return w;
  endfunction

  function automatic int field_diff(input string name, input logic [IDX_W-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    pixel_write_t got;
    pixel_write_t want;
    int bad;
    if (!rst_n) begin
      blit_cfg <= '{1'b0, DIM_W'(1), DIM_W'(1), sat_dim(CFG_DW'(DST_RESET)),
                    sat_dim(CFG_DW'(DST_RESET)), '0, '0};
      pending_writes.delete();
      accepted   <= 0;
      retired    <= 0;
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAINT_MODE: blit_cfg.paint_mode <= cfg_data[0];
          CFG_SRC_WIDTH:  blit_cfg.src_width  <= sat_dim(cfg_data);
          CFG_SRC_HEIGHT: blit_cfg.src_height <= sat_dim(cfg_data);
          CFG_DST_WIDTH:  blit_cfg.dst_width  <= sat_dim(cfg_data);
          CFG_DST_HEIGHT: blit_cfg.dst_height <= sat_dim(cfg_data);
          CFG_CENTER_X:   blit_cfg.center_x   <= signed'(cfg_data);
          CFG_CENTER_Y:   blit_cfg.center_y   <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (out_valid) begin
        got = {out_write_enable, out_dest_index, out_a, out_r, out_g, out_b};
        if (pending_writes.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_writes.pop_front();
          bad  = field_diff("write_enable", IDX_W'(want.we), IDX_W'(got.we)) +
                 field_diff("dest_index", want.idx, got.idx) +
                 field_diff("out_a", IDX_W'(want.a), IDX_W'(got.a)) +
                 field_diff("out_r", IDX_W'(want.r), IDX_W'(got.r)) +
                 field_diff("out_g", IDX_W'(want.g), IDX_W'(got.g)) +
                 field_diff("out_b", IDX_W'(want.b), IDX_W'(got.b));
          mismatches <= mismatches + bad;
          retired    <= retired + 1;
        end
      end
      if (start && !busy) begin
        pending_writes.push_back(predict_write(blit_cfg, in_pos_x, in_pos_y,
            in_src_a, in_src_r, in_src_g, in_src_b,
            in_under_a, in_under_r, in_under_g, in_under_b));
        accepted <= accepted + 1;
      end
    end
  end

  assign in_flight = accepted - retired;

endmodule

### tb/tb_clipped_alpha_blit_blend.sv
// testbench top: drives pixels and register writes into the blit and reports the verdict
module tb_clipped_alpha_blit_blend;
  import cabb_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PIPE_LAT    = 3;   // register stages of the block, used as a drain margin
  localparam int IDLE_PCT    = 20;
  localparam int POS_MAX     = 4095;
  localparam int CFG_DATA_MAX = 16383;
  // only index past the register list, writes to it are dropped
  localparam logic [CFG_IW-1:0] CFG_RESERVED = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [POS_W-1:0]  in_pos_x;
  logic [POS_W-1:0]  in_pos_y;
  logic [7:0]        in_src_a;
  logic [7:0]        in_src_r;
  logic [7:0]        in_src_g;
  logic [7:0]        in_src_b;
  logic [7:0]        in_under_a;
  logic [7:0]        in_under_r;
  logic [7:0]        in_under_g;
  logic [7:0]        in_under_b;
  logic              out_valid;
  logic              out_write_enable;
  logic [IDX_W-1:0]  out_dest_index;
  logic [7:0]        out_a;
  logic [7:0]        out_r;
  logic [7:0]        out_g;
  logic [7:0]        out_b;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  int   mismatches;
  int   in_flight;
  int   cycle_cnt = 0;
  // random idle cycles on both the pixel and the register channel
  bit   gaps_on;
  // effective sprite size, used to aim most random pixels inside the sprite
  int   cur_sw;
  int   cur_sh;

  clipped_alpha_blit_blend u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_src_a         (in_src_a),
    .in_src_r         (in_src_r),
    .in_src_g         (in_src_g),
    .in_src_b         (in_src_b),
    .in_under_a       (in_under_a),
    .in_under_r       (in_under_r),
    .in_under_g       (in_under_g),
    .in_under_b       (in_under_b),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_dest_index   (out_dest_index),
    .out_a            (out_a),
    .out_r            (out_r),
    .out_g            (out_g),
    .out_b            (out_b),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cabb_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_src_a         (in_src_a),
    .in_src_r         (in_src_r),
    .in_src_g         (in_src_g),
    .in_src_b         (in_src_b),
    .in_under_a       (in_under_a),
    .in_under_r       (in_under_r),
    .in_under_g       (in_under_g),
    .in_under_b       (in_under_b),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_dest_index   (out_dest_index),
    .out_a            (out_a),
    .out_r            (out_r),
    .out_g            (out_g),
    .out_b            (out_b),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .in_flight        (in_flight)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("clipped_alpha_blit_blend test failed");
      $finish;
    end
  end

  // one pixel transfer; start stays high on return so back-to-back items
  // never drop it within a time step
  task automatic send_pixel(input int px, py, sa, sr, sg, sb, ua, ur, ug, ub);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_pos_x   <= px[POS_W-1:0];
    in_pos_y   <= py[POS_W-1:0];
    in_src_a   <= sa[7:0];
    in_src_r   <= sr[7:0];
    in_src_g   <= sg[7:0];
    in_src_b   <= sb[7:0];
    in_under_a <= ua[7:0];
    in_under_r <= ur[7:0];
    in_under_g <= ug[7:0];
    in_under_b <= ub[7:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // one register write transfer; valid is left high for the next write
  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int val);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop issuing and wait for every outstanding result, then the pipe depth
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // dimension as the block holds it: low 13 bits, saturated
  function automatic int eff_dim(input int v);
    int d;
    d = v & 'h1FFF;
    return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : d;
  endfunction

  // new register set, only once the block is idle; the reserved index gets
  // a random write each time, which must change nothing
  task automatic set_config(input int pm, sw, sh, dw, dh, cx, cy);
    drain_pipe();
    cfg_write(CFG_PAINT_MODE, pm);
    cfg_write(CFG_SRC_WIDTH, sw);
    cfg_write(CFG_SRC_HEIGHT, sh);
    cfg_write(CFG_DST_WIDTH, dw);
    cfg_write(CFG_DST_HEIGHT, dh);
    cfg_write(CFG_CENTER_X, cx);
    cfg_write(CFG_CENTER_Y, cy);
    cfg_write(CFG_RESERVED, $urandom_range(0, CFG_DATA_MAX));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_sw = eff_dim(sw);
    cur_sh = eff_dim(sh);
  endtask

  // mostly pixels inside the sprite, a few anywhere in the 12-bit range;
  // alpha is weighted toward transparent and opaque
  task automatic random_pixels(input int count);
    int px;
    int py;
    int sa;
    int pick;
    repeat (count) begin
      if ($urandom_range(0, 99) < 85 && cur_sw > 0) px = $urandom_range(0, cur_sw - 1);
      else px = $urandom_range(0, POS_MAX);
      if ($urandom_range(0, 99) < 85 && cur_sh > 0) py = $urandom_range(0, cur_sh - 1);
      else py = $urandom_range(0, POS_MAX);
      pick = $urandom_range(0, 99);
      if (pick < 12) sa = 0;
      else if (pick < 24) sa = 255;
      else sa = $urandom_range(0, 255);
      send_pixel(px, py, sa, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int dw;
    int dh;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_pos_x   <= '0;
    in_pos_y   <= '0;
    in_src_a   <= '0;
    in_src_r   <= '0;
    in_src_g   <= '0;
    in_src_b   <= '0;
    in_under_a <= '0;
    in_under_r <= '0;
    in_under_g <= '0;
    in_under_b <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    gaps_on    = 1'b1;
    cur_sw     = 1;
    cur_sh     = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: copy mode, 1x1 sprite at the origin of a full-size target
    send_pixel(0, 0, 'hFF, 'hFF, 'hFF, 'hFF, 0, 0, 0, 0);
    send_pixel(0, 0, 0, 0, 0, 0, 'hFF, 'hFF, 'hFF, 'hFF);  // opaque copy keeps alpha 0
    send_pixel(1, 0, 'h12, 'h34, 'h56, 'h78, 1, 2, 3, 4);  // outside the sprite
    send_pixel(POS_MAX, POS_MAX, 'hAA, 'h55, 'hAA, 'h55, 'h55, 'hAA, 'h55, 'hAA);

    // blend mode, 8x8 sprite with its corner at (4,4) of a 16x16 target
    set_config(1, 8, 8, 16, 16, 8, 8);
    send_pixel(0, 0, 0, 10, 20, 30, 1, 2, 3, 4);            // transparent, no write
    send_pixel(1, 2, 'hFF, 1, 2, 3, 9, 9, 9, 9);            // opaque source is copied
    send_pixel(3, 3, 'h80, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);  // sum wraps
    send_pixel(7, 7, 1, 1, 0, 'hFF, 'hFF, 'hFF, 0, 'hFF);
    send_pixel(2, 5, 'hFE, 'hFE, 0, 'h7F, 'hFF, 'h80, 'hFF, 1);
    send_pixel(8, 0, 'h40, 'h40, 'h40, 'h40, 'h80, 'h80, 'h80, 'h80);  // outside the sprite

    // sprite hanging off the top-left corner of the target
    set_config(1, 8, 8, 16, 16, 0, 0);
    send_pixel(3, 3, 'h80, 'h10, 'h20, 'h30, 'h40, 'h50, 'h60, 'h70);
    send_pixel(4, 4, 'h80, 'h10, 'h20, 'h30, 'h40, 'h50, 'h60, 'h70);
    send_pixel(3, 4, 'h80, 'h10, 'h20, 'h30, 'h40, 'h50, 'h60, 'h70);

    // sprite hanging off the bottom-right corner
    set_config(0, 8, 8, 16, 16, 14, 14);
    send_pixel(5, 5, 'h33, 'h22, 'h11, 'h00, 'hFF, 'hFF, 'hFF, 'hFF);
    send_pixel(6, 5, 'h33, 'h22, 'h11, 'h00, 'hFF, 'hFF, 'hFF, 'hFF);
    send_pixel(5, 6, 'h33, 'h22, 'h11, 'h00, 'hFF, 'hFF, 'hFF, 'hFF);

    // zero sprite width, then zero target width: nothing lands
    set_config(1, 0, 8, 16, 16, 8, 8);
    send_pixel(0, 0, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80);
    set_config(1, 8, 8, 0, 16, 8, 8);
    send_pixel(0, 0, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80);

    // oversized dimensions saturate to the maximum
    set_config(0, CFG_DATA_MAX, 8191, CFG_DATA_MAX, 5000, 0, 0);
    send_pixel(POS_MAX, POS_MAX, 'hFF, 'h01, 'h02, 'h03, 0, 0, 0, 0);
    send_pixel(2048, 2048, 'h7F, 'h80, 'h81, 'h82, 'hFF, 'hFF, 'hFF, 'hFF);

    // random part: fixed shapes first, then random placements
    set_config(1, 64, 48, 320, 240, 160, 120);
    random_pixels(200);
    // full-size sprite over a full-size target reaches every index bit
    set_config(1, 4096, 4096, 4096, 4096, 2048, 2048);
    random_pixels(200);
    // back-to-back stretch with no idle cycles, partly clipped
    gaps_on = 1'b0;
    set_config(0, 100, 100, 64, 64, 10, -5);
    random_pixels(200);
    gaps_on = 1'b1;
    // extreme centres
    set_config(1, 4096, 3, 4096, 1, -8192, 8191);
    random_pixels(30);
    set_config(1, 4096, 4096, 4096, 4096, 8191, -8192);
    random_pixels(30);
    set_config(1, 1, 1, 1, 1, 0, 0);
    random_pixels(30);
    repeat (8) begin
      dw = $urandom_range(1, 200);
      dh = $urandom_range(1, 200);
      set_config($urandom_range(0, 1), $urandom_range(1, 64), $urandom_range(1, 64), dw, dh,
                 int'($urandom_range(0, dw + 40)) - 20, int'($urandom_range(0, dh + 40)) - 20);
      random_pixels(110);
    end

    drain_pipe();
    if (mismatches == 0 && in_flight == 0) begin
      $display("clipped_alpha_blit_blend test passed");
    end else begin
      $display("clipped_alpha_blit_blend test failed");
    end
    $finish;
  end

endmodule
